### src/fapid_pkg.sv
// ----------------------------------------------------------------------------
// fapid_pkg
// Shared types, register indexes, sequencer codes and the rule table of the
// fuzzy adaptive PID core.
// ----------------------------------------------------------------------------
package fapid_pkg;

    localparam int SET_COUNT = 7;

    // Configuration register indexes
    localparam logic [3:0] REG_GAIN_PROP   = 4'd0;
    localparam logic [3:0] REG_GAIN_INTEG  = 4'd1;
    localparam logic [3:0] REG_GAIN_DERIV  = 4'd2;
    localparam logic [3:0] REG_IN_LOWER    = 4'd3;
    localparam logic [3:0] REG_IN_UPPER    = 4'd4;
    localparam logic [3:0] REG_DRIVE_LOWER = 4'd5;
    localparam logic [3:0] REG_DRIVE_UPPER = 4'd6;
    localparam logic [3:0] REG_PERIOD_MS   = 4'd7;

    localparam logic [14:0] PERIOD_MIN = 15'd1;
    localparam logic [14:0] PERIOD_MAX = 15'd30000;

    // Saturation bound of every scaled product
    localparam logic [63:0] MD_SAT = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic        [15:0] gain_prop;
        logic        [15:0] gain_integ;
        logic        [15:0] gain_deriv;
        logic signed [15:0] ilo;
        logic signed [15:0] ihi;
        logic signed [15:0] olo;
        logic signed [15:0] ohi;
        logic        [14:0] period;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] q;
    } md_rsp_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_CHK,
        M_DIV,
        M_FIN
    } md_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_ISSUE,
        S_WAIT,
        S_FUZZ,
        S_RULE,
        S_FINISH,
        S_EMIT
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_DER,
        OP_MAPE,
        OP_MAPD,
        OP_CENT,
        OP_FZ,
        OP_FZ10,
        OP_GP,
        OP_GI,
        OP_GD,
        OP_INTEG,
        OP_LIM,
        OP_T1,
        OP_T2,
        OP_T3
    } op_t;

    localparam logic [2:0] RULE_TAB [SET_COUNT][SET_COUNT] = '{
        '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
        '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4},
        '{3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4},
        '{3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5},
        '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5},
        '{3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6},
        '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6}
    };

    function automatic logic [2:0] rule_at(input logic [2:0] i, input logic [2:0] j);
        logic [2:0] k;
        k = 3'd0;
        if (i < 3'(SET_COUNT) && j < 3'(SET_COUNT))
        begin
            k = RULE_TAB[i][j];
        end
        return k;
    endfunction

endpackage

### src/fapid_if.sv
// ----------------------------------------------------------------------------
// fapid_if
// Channel interfaces of the fuzzy adaptive PID core: samples, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface fapid_sample_if;
    logic               valid;
    logic               ready;
    logic        [31:0] now_ms;
    logic signed [15:0] target;
    logic signed [15:0] measured;

    modport source (output valid, output now_ms, output target, output measured,
                    input ready);
    modport sink   (input valid, input now_ms, input target, input measured,
                    output ready);
endinterface

interface fapid_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               updated;

    modport source (output valid, output drive, output updated, input ready);
    modport sink   (input valid, input drive, input updated, output ready);
endinterface

interface fapid_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/fapid_cfg.sv
// ----------------------------------------------------------------------------
// fapid_cfg
// Configuration register file; presents ordered universes and a clamped
// sample period.
// ----------------------------------------------------------------------------
module fapid_cfg (
    input  logic            clk,
    input  logic            rst_n,
    fapid_cfg_if.sink       cfg,
    output fapid_pkg::cfg_t cfg_q
);
    import fapid_pkg::*;

    logic        [15:0] gain_prop_reg;
    logic        [15:0] gain_integ_reg;
    logic        [15:0] gain_deriv_reg;
    logic signed [15:0] in_lower_reg;
    logic signed [15:0] in_upper_reg;
    logic signed [15:0] drive_lower_reg;
    logic signed [15:0] drive_upper_reg;
    logic        [14:0] period_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= 16'd256;
            gain_integ_reg  <= 16'd0;
            gain_deriv_reg  <= 16'd0;
            in_lower_reg    <= -16'sd100;
            in_upper_reg    <= 16'sd100;
            drive_lower_reg <= -16'sd255;
            drive_upper_reg <= 16'sd255;
            period_reg      <= 15'd100;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_GAIN_PROP:   gain_prop_reg   <= cfg.data;
                REG_GAIN_INTEG:  gain_integ_reg  <= cfg.data;
                REG_GAIN_DERIV:  gain_deriv_reg  <= cfg.data;
                REG_IN_LOWER:    in_lower_reg    <= $signed(cfg.data);
                REG_IN_UPPER:    in_upper_reg    <= $signed(cfg.data);
                REG_DRIVE_LOWER: drive_lower_reg <= $signed(cfg.data);
                REG_DRIVE_UPPER: drive_upper_reg <= $signed(cfg.data);
                REG_PERIOD_MS:   period_reg      <= cfg.data[14:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg_q.gain_prop  = gain_prop_reg;
        cfg_q.gain_integ = gain_integ_reg;
        cfg_q.gain_deriv = gain_deriv_reg;
        if (in_lower_reg < in_upper_reg)
        begin
            cfg_q.ilo = in_lower_reg;
            cfg_q.ihi = in_upper_reg;
        end
        else
        begin
            cfg_q.ilo = in_upper_reg;
            cfg_q.ihi = in_lower_reg;
        end
        if (drive_lower_reg < drive_upper_reg)
        begin
            cfg_q.olo = drive_lower_reg;
            cfg_q.ohi = drive_upper_reg;
        end
        else
        begin
            cfg_q.olo = drive_upper_reg;
            cfg_q.ohi = drive_lower_reg;
        end
        if (period_reg < PERIOD_MIN)
        begin
            cfg_q.period = PERIOD_MIN;
        end
        else if (period_reg > PERIOD_MAX)
        begin
            cfg_q.period = PERIOD_MAX;
        end
        else
        begin
            cfg_q.period = period_reg;
        end
    end

endmodule

### src/fapid_muldiv.sv
// ----------------------------------------------------------------------------
// fapid_muldiv
// Shared a*b/c unit: 128-bit magnitude product from four 32x32 partial
// products, then restoring division one quotient bit per cycle. Truncates
// toward zero, saturates at +-2^60, divisor zero gives zero.
// ----------------------------------------------------------------------------
module fapid_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  fapid_pkg::md_req_t req,
    output fapid_pkg::md_rsp_t rsp
);
    import fapid_pkg::*;

    md_state_t          state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [63:0]        ua_reg, ua_next;
    logic [63:0]        ub_reg, ub_next;
    logic [63:0]        uc_reg, uc_next;
    logic               neg_reg, neg_next;
    logic [127:0]       prod_reg, prod_next;
    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        lo_reg, lo_next;
    logic [63:0]        q_reg, q_next;
    logic signed [63:0] res_reg, res_next;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    logic [64:0]  rem_sh;
    logic [63:0]  q_sat;

    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    assign a_part = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_part = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign pp     = a_part * b_part;
    assign rem_sh = {rem_reg, lo_reg[63]};
    assign q_sat  = (q_reg > MD_SAT) ? MD_SAT : q_reg;

    always_comb
    begin
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_shift = {64'd0, pp};
            2'd1:    pp_shift = {32'd0, pp, 32'd0};
            default: pp_shift = {pp, 64'd0};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        uc_next    = uc_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    ua_next    = magn(req.a);
                    ub_next    = magn(req.b);
                    uc_next    = magn(req.c);
                    neg_next   = (req.a[63] ^ req.b[63]) ^ req.c[63];
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                prod_next = prod_reg + pp_shift;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = M_CHK;
                end
            end
            M_CHK:
            begin
                // Settle the trivial divisors and the overflow case here, run the bit loop otherwise.
                state_next = M_FIN;
                if (uc_reg == 64'd0)
                begin
                    q_next = '0;
                end
                else if (prod_reg[127:64] >= uc_reg)
                begin
                    q_next = MD_SAT;
                end
                else if (uc_reg == 64'd1)
                begin
                    q_next = prod_reg[63:0];
                end
                else
                begin
                    rem_next   = prod_reg[127:64];
                    lo_next    = prod_reg[63:0];
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = M_DIV;
                end
            end
            M_DIV:
            begin
                lo_next = {lo_reg[62:0], 1'b0};
                if (rem_sh >= {1'b0, uc_reg})
                begin
                    rem_next = rem_sh[63:0] - uc_reg;
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[63:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                res_next   = neg_reg ? -$signed(q_sat) : $signed(q_sat);
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        uc_reg   <= uc_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = res_reg;

endmodule

### src/fuzzy_adaptive_pid_core.sv
// ----------------------------------------------------------------------------
// fuzzy_adaptive_pid_core
// Fuzzy self-tuning PID controller, 7x7 Mamdani max-min inference, built
// around one shared multiply-divide unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one beat per control sample (now_ms, target, measured).
//   result : one beat per sample (drive, updated), in sample order.
//   cfg    : register writes, always ready; write only while the core idles.
// A sample that arrives before period_ms has elapsed since the last update
// yields drive 0 / updated 0 and leaves the controller state untouched. An
// updating sample runs ten multiply-divide passes (4 partial products plus
// a 64-step restoring division each), ten multiply-only passes (seven
// centroid weights and three gain scalings), a membership sweep of the seven
// sets per input and a sweep of the 7x7 rule table. sample.ready is high
// only in the idle state.
// The result register holds a finished beat while the receiver stalls; the
// next sample is still accepted and waits at its end for that register.
// Reset restores the register defaults, clears the integrator, the previous
// error and time, and arms the first-update flag.
// ----------------------------------------------------------------------------
module fuzzy_adaptive_pid_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    fapid_sample_if.sink  sample,
    fapid_result_if.source result,
    fapid_cfg_if.sink     cfg
);
    import fapid_pkg::*;

    localparam int MUW  = FRAC_BITS + 1;
    localparam int SUMW = MUW + 3;
    localparam logic signed [63:0] FX_ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] K_DER   = FX_ONE * 64'sd1000;
    localparam logic signed [63:0] K_256   = FX_ONE * 64'sd256;
    localparam logic signed [63:0] LIM_EPS = (FX_ONE * 64'sd256) / 64'sd1000;
    localparam logic [SUMW-1:0]    SUM_MIN = SUMW'((64'd1 << FRAC_BITS) / 64'd1000);
    localparam logic signed [63:0] ACC_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] ACC_MIN = -(64'sd1 <<< 47);

    cfg_t    cfg_q;
    md_req_t md_req;
    md_rsp_t md_rsp;

    fapid_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    fapid_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Control state
    ctl_state_t         state_reg, state_next;
    op_t                op_reg, op_next;
    logic [2:0]         idx_reg, idx_next;
    logic [2:0]         i_reg, i_next;
    logic [2:0]         j_reg, j_next;
    logic               first_reg, first_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic signed [16:0] prev_error_reg, prev_error_next;
    logic signed [47:0] integ_acc_reg, integ_acc_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath
    logic [31:0]        now_reg, now_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [15:0] measured_reg, measured_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [16:0] err_reg, err_next;
    logic signed [63:0] der_reg, der_next;
    logic signed [63:0] mapq_reg, mapq_next;
    logic [MUW-1:0]     me_reg [SET_COUNT];
    logic [MUW-1:0]     me_next [SET_COUNT];
    logic [MUW-1:0]     md_reg [SET_COUNT];
    logic [MUW-1:0]     md_next [SET_COUNT];
    logic [MUW-1:0]     agg_reg [SET_COUNT];
    logic [MUW-1:0]     agg_next [SET_COUNT];
    logic [SUMW-1:0]    sum_reg, sum_next;
    logic signed [63:0] num_reg, num_next;
    logic signed [21:0] w_reg, w_next;
    logic signed [63:0] fz_reg, fz_next;
    logic signed [63:0] fac_reg, fac_next;
    logic signed [63:0] gp_reg, gp_next;
    logic signed [63:0] gi_reg, gi_next;
    logic signed [63:0] gd_reg, gd_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] drv_reg, drv_next;
    logic signed [15:0] drive_w_reg, drive_w_next;
    logic               upd_reg, upd_next;
    logic signed [15:0] drive_out_reg, drive_out_next;
    logic               updated_out_reg, updated_out_next;

    // Helpers
    logic [31:0]        dt_raw;
    logic signed [63:0] err_q;
    logic signed [63:0] ilo_q;
    logic signed [63:0] ohi_q;
    logic signed [63:0] olo_q;
    logic signed [16:0] den;
    logic signed [21:0] span;
    logic signed [21:0] olo_x;
    logic signed [21:0] w_init;
    logic signed [17:0] err_diff;
    logic signed [63:0] fz_d;
    logic signed [63:0] fz_ad;
    logic [MUW-1:0]     mu;
    logic [MUW-1:0]     rule_s;
    logic [2:0]         rule_k;
    logic [SUMW-1:0]    sum_acc;
    logic [63:0]        sum6;
    logic signed [63:0] acc_int;
    logic signed [63:0] lim_div;
    logic signed [63:0] acc_lim;
    logic signed [63:0] drv_c;
    logic signed [63:0] drv_r;

    function automatic logic signed [63:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > ACC_MAX)
        begin
            r = ACC_MAX;
        end
        else if (v < ACC_MIN)
        begin
            r = ACC_MIN;
        end
        return r;
    endfunction

    assign dt_raw   = now_reg - prev_time_reg;
    assign err_q    = 64'(err_reg) <<< FRAC_BITS;
    assign ilo_q    = 64'(cfg_q.ilo) <<< FRAC_BITS;
    assign ohi_q    = 64'(cfg_q.ohi) <<< FRAC_BITS;
    assign olo_q    = 64'(cfg_q.olo) <<< FRAC_BITS;
    assign den      = 17'(cfg_q.ihi) - 17'(cfg_q.ilo);
    assign span     = 22'(cfg_q.ohi) - 22'(cfg_q.olo);
    assign olo_x    = 22'(cfg_q.olo);
    assign w_init   = (olo_x <<< 2) + (olo_x <<< 1);
    assign err_diff = 18'(err_reg) - 18'(prev_error_reg);

    // Membership of set idx: distance from the set centre on the normalised axis
    assign fz_d  = mapq_reg - ($signed({61'd0, idx_reg}) <<< FRAC_BITS);
    assign fz_ad = fz_d[63] ? -fz_d : fz_d;
    assign mu    = (fz_ad >= FX_ONE) ? '0 : MUW'(FX_ONE - fz_ad);

    assign rule_s  = (me_reg[i_reg] < md_reg[j_reg]) ? me_reg[i_reg] : md_reg[j_reg];
    assign rule_k  = rule_at(i_reg, j_reg);
    assign sum_acc = sum_reg + SUMW'(agg_reg[idx_reg]);
    assign sum6    = ({{(64-SUMW){1'b0}}, sum_reg} << 2)
                   + ({{(64-SUMW){1'b0}}, sum_reg} << 1);

    assign acc_int = 64'(integ_acc_reg) + md_rsp.q;
    assign lim_div = gi_reg + LIM_EPS;
    assign acc_lim = (acc_reg > md_rsp.q) ? md_rsp.q
                   : ((acc_reg < -md_rsp.q) ? -md_rsp.q : acc_reg);

    assign drv_c = (drv_reg > ohi_q) ? ohi_q : ((drv_reg < olo_q) ? olo_q : drv_reg);
    assign drv_r = drv_c[63] ? (drv_c + (FX_ONE - 64'sd1)) : drv_c;

    // Operand select for the shared unit
    always_comb
    begin
        md_req.start = (state_reg == S_ISSUE);
        md_req.a     = '0;
        md_req.b     = '0;
        md_req.c     = 64'sd1;
        case (op_reg)
            OP_DER:
            begin
                md_req.a = 64'(err_diff);
                md_req.b = K_DER;
                md_req.c = $signed({32'd0, dt_reg});
            end
            OP_MAPE:
            begin
                md_req.a = err_q - ilo_q;
                md_req.b = 64'(SET_COUNT - 1);
                md_req.c = 64'(den);
            end
            OP_MAPD:
            begin
                md_req.a = der_reg - ilo_q;
                md_req.b = 64'(SET_COUNT - 1);
                md_req.c = 64'(den);
            end
            OP_CENT:
            begin
                md_req.a = $signed({{(64-MUW){1'b0}}, agg_reg[idx_reg]});
                md_req.b = 64'(w_reg);
                md_req.c = 64'sd1;
            end
            OP_FZ:
            begin
                md_req.a = num_reg;
                md_req.b = FX_ONE;
                md_req.c = $signed(sum6);
            end
            OP_FZ10:
            begin
                md_req.a = fz_reg;
                md_req.b = 64'sd1;
                md_req.c = 64'sd10;
            end
            OP_GP:
            begin
                md_req.a = $signed({48'd0, cfg_q.gain_prop});
                md_req.b = fac_reg;
            end
            OP_GI:
            begin
                md_req.a = $signed({48'd0, cfg_q.gain_integ});
                md_req.b = fac_reg;
            end
            OP_GD:
            begin
                md_req.a = $signed({48'd0, cfg_q.gain_deriv});
                md_req.b = fac_reg;
            end
            OP_INTEG:
            begin
                md_req.a = err_q;
                md_req.b = $signed({32'd0, dt_reg});
                md_req.c = 64'sd1000;
            end
            OP_LIM:
            begin
                md_req.a = ohi_q;
                md_req.b = K_256;
                md_req.c = lim_div;
            end
            OP_T1:
            begin
                md_req.a = gp_reg;
                md_req.b = err_q;
                md_req.c = K_256;
            end
            OP_T2:
            begin
                md_req.a = gi_reg;
                md_req.b = acc_reg;
                md_req.c = K_256;
            end
            OP_T3:
            begin
                md_req.a = gd_reg;
                md_req.b = der_reg;
                md_req.c = K_256;
            end
            default:
            begin
                md_req.c = 64'sd1;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        first_next       = first_reg;
        prev_time_next   = prev_time_reg;
        prev_error_next  = prev_error_reg;
        integ_acc_next   = integ_acc_reg;
        out_valid_next   = out_valid_reg;
        now_next         = now_reg;
        target_next      = target_reg;
        measured_next    = measured_reg;
        dt_next          = dt_reg;
        err_next         = err_reg;
        der_next         = der_reg;
        mapq_next        = mapq_reg;
        me_next          = me_reg;
        md_next          = md_reg;
        agg_next         = agg_reg;
        sum_next         = sum_reg;
        num_next         = num_reg;
        w_next           = w_reg;
        fz_next          = fz_reg;
        fac_next         = fac_reg;
        gp_next          = gp_reg;
        gi_next          = gi_reg;
        gd_next          = gd_reg;
        acc_next         = acc_reg;
        drv_next         = drv_reg;
        drive_w_next     = drive_w_reg;
        upd_next         = upd_reg;
        drive_out_next   = drive_out_reg;
        updated_out_next = updated_out_reg;
        sample.ready     = (state_reg == S_IDLE);

        // Drop the result beat once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    now_next      = sample.now_ms;
                    target_next   = sample.target;
                    measured_next = sample.measured;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!first_reg && (dt_raw < {17'd0, cfg_q.period}))
                begin
                    drive_w_next = '0;
                    upd_next     = 1'b0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    dt_next        = first_reg ? {17'd0, cfg_q.period} : dt_raw;
                    first_next     = 1'b0;
                    prev_time_next = now_reg;
                    err_next       = 17'(target_reg) - 17'(measured_reg);
                    for (int k = 0; k < SET_COUNT; k++)
                    begin
                        agg_next[k] = '0;
                    end
                    op_next    = OP_DER;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                begin
                    state_next = S_ISSUE;
                    case (op_reg)
                        OP_DER:
                        begin
                            der_next = md_rsp.q;
                            if (den == 17'sd0)
                            begin
                                // Empty input universe: no fuzzy correction
                                fz_next = '0;
                                op_next = OP_FZ10;
                            end
                            else
                            begin
                                op_next = OP_MAPE;
                            end
                        end
                        OP_MAPE, OP_MAPD:
                        begin
                            mapq_next  = md_rsp.q;
                            idx_next   = '0;
                            state_next = S_FUZZ;
                        end
                        OP_CENT:
                        begin
                            num_next = num_reg + md_rsp.q;
                            sum_next = sum_acc;
                            w_next   = w_reg + span;
                            idx_next = idx_reg + 3'd1;
                            if (idx_reg == 3'(SET_COUNT - 1))
                            begin
                                if (sum_acc <= SUM_MIN)
                                begin
                                    // Weak aggregate: no fuzzy correction
                                    fz_next = '0;
                                    op_next = OP_FZ10;
                                end
                                else
                                begin
                                    op_next = OP_FZ;
                                end
                            end
                        end
                        OP_FZ:
                        begin
                            fz_next = md_rsp.q;
                            op_next = OP_FZ10;
                        end
                        OP_FZ10:
                        begin
                            fac_next = FX_ONE + md_rsp.q;
                            op_next  = OP_GP;
                        end
                        OP_GP:
                        begin
                            gp_next = md_rsp.q;
                            op_next = OP_GI;
                        end
                        OP_GI:
                        begin
                            gi_next = md_rsp.q;
                            op_next = OP_GD;
                        end
                        OP_GD:
                        begin
                            gd_next = md_rsp.q;
                            op_next = OP_INTEG;
                        end
                        OP_INTEG:
                        begin
                            if (lim_div != 64'sd0)
                            begin
                                acc_next = acc_int;
                                op_next  = OP_LIM;
                            end
                            else
                            begin
                                acc_next       = sat48(acc_int);
                                integ_acc_next = 48'(sat48(acc_int));
                                op_next        = OP_T1;
                            end
                        end
                        OP_LIM:
                        begin
                            // Anti-windup clamp, then fit the accumulator width
                            acc_next       = sat48(acc_lim);
                            integ_acc_next = 48'(sat48(acc_lim));
                            op_next        = OP_T1;
                        end
                        OP_T1:
                        begin
                            drv_next = md_rsp.q;
                            op_next  = OP_T2;
                        end
                        OP_T2:
                        begin
                            drv_next = drv_reg + md_rsp.q;
                            op_next  = OP_T3;
                        end
                        OP_T3:
                        begin
                            drv_next   = drv_reg + md_rsp.q;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FUZZ:
            begin
                if (op_reg == OP_MAPE)
                begin
                    me_next[idx_reg] = mu;
                end
                else
                begin
                    md_next[idx_reg] = mu;
                end
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'(SET_COUNT - 1))
                begin
                    if (op_reg == OP_MAPE)
                    begin
                        op_next    = OP_MAPD;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_RULE;
                    end
                end
            end
            S_RULE:
            begin
                if (rule_s > agg_reg[rule_k])
                begin
                    agg_next[rule_k] = rule_s;
                end
                j_next = j_reg + 3'd1;
                if (j_reg == 3'(SET_COUNT - 1))
                begin
                    j_next = '0;
                    i_next = i_reg + 3'd1;
                    if (i_reg == 3'(SET_COUNT - 1))
                    begin
                        idx_next   = '0;
                        sum_next   = '0;
                        num_next   = '0;
                        w_next     = w_init;
                        op_next    = OP_CENT;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINISH:
            begin
                drive_w_next    = 16'(drv_r >>> FRAC_BITS);
                upd_next        = 1'b1;
                prev_error_next = err_reg;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    drive_out_next   = drive_w_reg;
                    updated_out_next = upd_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_DER;
            idx_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            first_reg      <= 1'b1;
            prev_time_reg  <= '0;
            prev_error_reg <= '0;
            integ_acc_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            first_reg      <= first_next;
            prev_time_reg  <= prev_time_next;
            prev_error_reg <= prev_error_next;
            integ_acc_reg  <= integ_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        target_reg      <= target_next;
        measured_reg    <= measured_next;
        dt_reg          <= dt_next;
        err_reg         <= err_next;
        der_reg         <= der_next;
        mapq_reg        <= mapq_next;
        me_reg          <= me_next;
        md_reg          <= md_next;
        agg_reg         <= agg_next;
        sum_reg         <= sum_next;
        num_reg         <= num_next;
        w_reg           <= w_next;
        fz_reg          <= fz_next;
        fac_reg         <= fac_next;
        gp_reg          <= gp_next;
        gi_reg          <= gi_next;
        gd_reg          <= gd_next;
        acc_reg         <= acc_next;
        drv_reg         <= drv_next;
        drive_w_reg     <= drive_w_next;
        upd_reg         <= upd_next;
        drive_out_reg   <= drive_out_next;
        updated_out_reg <= updated_out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.drive   = drive_out_reg;
    assign result.updated = updated_out_reg;

endmodule

### src/fapid_checker.sv
// ----------------------------------------------------------------------------
// fapid_checker
// Port-level checks of the fuzzy adaptive PID core, bound to the top level.
// ----------------------------------------------------------------------------
module fapid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [15:0] result_drive,
    input logic        result_updated
);

    // One sample at a time: busy right after a sample beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample accepted while a previous sample was in work");

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_drive) && $stable(result_updated))
        else $error("stalled result beat changed");

    // A skipped sample drives zero
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_updated |-> result_drive == 16'd0)
        else $error("non-updated result carries a nonzero drive");

endmodule

bind fuzzy_adaptive_pid_core fapid_checker u_fapid_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample.valid),
    .sample_ready   (sample.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_drive   (result.drive),
    .result_updated (result.updated)
);
